// ===== hw/rtl/nprbs_pkg.sv =====
// Package for the NAND large-page read sequencer with bad-block skipping.
// Holds the item structs, the event and action codes and the job descriptor.
// No dependencies.
package nprbs_pkg;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_READY = 2'd1,
    FUNC_BYTE  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ACT_SELECT   = 3'd0,
    ACT_DESELECT = 3'd1,
    ACT_COMMAND  = 3'd2,
    ACT_ADDRESS  = 3'd3,
    ACT_STROBE   = 3'd4,
    ACT_DELIVER  = 3'd5,
    ACT_DONE     = 3'd6,
    ACT_SPARE    = 3'd7
  } action_e;

  typedef enum logic [4:0] {
    PH_IDLE        = 5'b00001,
    PH_SPARE_READY = 5'b00010,
    PH_SPARE_BYTE  = 5'b00100,
    PH_DATA_READY  = 5'b01000,
    PH_DATA_BYTE   = 5'b10000
  } phase_e;

  localparam logic [7:0] CMD_READ    = 8'h00;
  localparam logic [7:0] CMD_CONFIRM = 8'h30;
  localparam logic [7:0] GOOD_MARK   = 8'hff;

  // Number of bus actions in one read sequence: select, two commands, five address bytes.
  localparam int unsigned IssueSteps = 8;
  localparam int unsigned SubW       = $clog2(IssueSteps);

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] start_address;
    logic [31:0] read_length;
    logic [7:0]  flash_byte;
  } in_item_t;

  typedef struct packed {
    action_e     action;
    logic [7:0]  bus_byte;
    logic [31:0] buffer_index;
    logic        last;
  } out_item_t;

  // Work handed from the front to the back. The back emits the enabled
  // parts in this order: deliver, deselect, read sequence, strobe, done.
  typedef struct packed {
    logic        deliver;
    logic        deselect;
    logic        issue;
    logic        strobe;
    logic        done;
    logic [7:0]  data;
    logic [31:0] index;
    logic [15:0] col;
    logic [23:0] page;
  } job_t;

endpackage

// ===== hw/rtl/nprbs_front.sv =====
// Front part of the read sequencer: takes each input item, advances the read
// state and turns the item into a job descriptor if it calls for any work. Depends on nprbs_pkg.
module nprbs_front
  import nprbs_pkg::*;
#(
  parameter int unsigned PAGE_BYTES  = 2048,
  parameter int unsigned BLOCK_BYTES = 131072
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  output logic     job_valid_o,
  output job_t     job_o
);

  localparam int unsigned PageLog  = $clog2(PAGE_BYTES);
  localparam int unsigned BlockLog = $clog2(BLOCK_BYTES);
  localparam int unsigned ColW     = PageLog;

  phase_e          phase_q, phase_d;
  logic [31:0]     addr_q, addr_d;
  logic [31:0]     done_q, done_d;
  logic [31:0]     len_q, len_d;
  logic [ColW-1:0] column_q, column_d;

  logic            do_issue, iss_check, iss_spare;
  logic [ColW:0]   column_inc;
  logic [31:0]     done_inc;
  job_t            job;

  assign column_inc = {1'b0, column_q} + {{ColW{1'b0}}, 1'b1};
  assign done_inc   = done_q + 32'd1;

  always_comb begin
    phase_d   = phase_q;
    addr_d    = addr_q;
    done_d    = done_q;
    len_d     = len_q;
    column_d  = column_q;
    do_issue  = 1'b0;
    iss_check = 1'b1;
    job       = '0;

    case (func_e'(item_i.func))
      FUNC_START: begin
        addr_d   = item_i.start_address;
        len_d    = item_i.read_length;
        done_d   = '0;
        column_d = item_i.start_address[ColW-1:0];
        if (item_i.read_length == 32'd0) begin
          phase_d  = PH_IDLE;
          job.done = 1'b1;
        end else begin
          do_issue = 1'b1;
        end
      end
      FUNC_READY: begin
        if (phase_q == PH_SPARE_READY) begin
          job.strobe = 1'b1;
          phase_d    = PH_SPARE_BYTE;
        end else if (phase_q == PH_DATA_READY) begin
          job.strobe = 1'b1;
          phase_d    = PH_DATA_BYTE;
        end
      end
      FUNC_BYTE: begin
        if (phase_q == PH_SPARE_BYTE) begin
          job.deselect = 1'b1;
          do_issue     = 1'b1;
          if (item_i.flash_byte != GOOD_MARK) begin
            addr_d = addr_q + 32'(BLOCK_BYTES);
          end else begin
            iss_check = 1'b0;
          end
        end else if (phase_q == PH_DATA_BYTE) begin
          job.deliver = 1'b1;
          job.data    = item_i.flash_byte;
          job.index   = done_q;
          done_d      = done_inc;
          addr_d      = addr_q + 32'd1;
          column_d    = column_inc[ColW-1:0];
          if (done_inc == len_q) begin
            job.deselect = 1'b1;
            job.done     = 1'b1;
            phase_d      = PH_IDLE;
            column_d     = '0;
          end else if (column_inc[ColW]) begin
            job.deselect = 1'b1;
            column_d     = '0;
            do_issue     = 1'b1;
          end else begin
            job.strobe = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // A read sequence starting on a block boundary first fetches the spare byte.
    iss_spare = iss_check && (addr_d[BlockLog-1:0] == '0);
    if (do_issue) begin
      job.issue = 1'b1;
      job.col   = iss_spare ? 16'(PAGE_BYTES) : 16'(column_d);
      job.page  = 24'(addr_d >> PageLog);
      phase_d   = iss_spare ? PH_SPARE_READY : PH_DATA_READY;
    end
  end

  assign job_o       = job;
  assign job_valid_o = accept_i &&
                       (job.deliver || job.deselect || job.issue || job.strobe || job.done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      addr_q   <= '0;
      done_q   <= '0;
      len_q    <= '0;
      column_q <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      addr_q   <= addr_d;
      done_q   <= done_d;
      len_q    <= len_d;
      column_q <= column_d;
    end
  end

endmodule

// ===== hw/rtl/nprbs_queue.sv =====
// Short job queue between the front and the back of the read sequencer.
// Register-based circular buffer of job descriptors. Depends on nprbs_pkg.
module nprbs_queue
  import nprbs_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t job_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);

  job_t          mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == (PtrW + 1)'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (PtrW + 1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (PtrW + 1)'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PtrW + 1)'(DEPTH))
    else $error("queue fill count exceeds its depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job pushed into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push && count_q == (PtrW + 1)'(1)) |=> empty_o)
    else $error("queue not empty after its last job was taken");

endmodule

// ===== hw/rtl/nprbs_back.sv =====
// Back part of the read sequencer: expands one job descriptor into bus actions,
// one result item per cycle while results are popped, and presents them as a queue head. Depends on nprbs_pkg.
module nprbs_back
  import nprbs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_empty_i,
  input  job_t      job_i,
  output logic      job_pop_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t out_item_o
);

  job_t            job_q, job_d;
  logic            busy_q, busy_d;
  logic [SubW-1:0] sub_q, sub_d;
  job_t            rest;
  out_item_t       item;
  logic            last, take;

  // Build the current result and the job left once it has been taken.
  always_comb begin
    item = '0;
    rest = job_q;
    if (job_q.deliver) begin
      item.action       = ACT_DELIVER;
      item.bus_byte     = job_q.data;
      item.buffer_index = job_q.index;
      rest.deliver      = 1'b0;
    end else if (job_q.deselect) begin
      item.action   = ACT_DESELECT;
      rest.deselect = 1'b0;
    end else if (job_q.issue) begin
      unique case (sub_q)
        3'd0: item.action = ACT_SELECT;
        3'd1: begin
          item.action   = ACT_COMMAND;
          item.bus_byte = CMD_READ;
        end
        3'd2: begin
          item.action   = ACT_ADDRESS;
          item.bus_byte = job_q.col[7:0];
        end
        3'd3: begin
          item.action   = ACT_ADDRESS;
          item.bus_byte = job_q.col[15:8];
        end
        3'd4: begin
          item.action   = ACT_ADDRESS;
          item.bus_byte = job_q.page[7:0];
        end
        3'd5: begin
          item.action   = ACT_ADDRESS;
          item.bus_byte = job_q.page[15:8];
        end
        3'd6: begin
          item.action   = ACT_ADDRESS;
          item.bus_byte = job_q.page[23:16];
        end
        default: begin
          item.action   = ACT_COMMAND;
          item.bus_byte = CMD_CONFIRM;
        end
      endcase
      if (sub_q == SubW'(IssueSteps - 1)) begin
        rest.issue = 1'b0;
      end
    end else if (job_q.strobe) begin
      item.action = ACT_STROBE;
      rest.strobe = 1'b0;
    end else begin
      item.action = ACT_DONE;
      rest.done   = 1'b0;
    end
    last      = !(rest.deliver || rest.deselect || rest.issue || rest.strobe || rest.done);
    item.last = last;
  end

  assign take       = busy_q && pop_i;
  assign job_pop_o  = (!busy_q || (take && last)) && !job_empty_i;
  assign empty_o    = !busy_q;
  assign out_item_o = item;

  always_comb begin
    job_d  = job_q;
    busy_d = busy_q;
    sub_d  = sub_q;
    if (take) begin
      job_d = rest;
      if (job_q.issue && !job_q.deliver && !job_q.deselect) begin
        sub_d = sub_q + SubW'(1);
      end
    end
    if (!busy_q || (take && last)) begin
      busy_d = !job_empty_i;
      job_d  = job_i;
      sub_d  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sub_q  <= '0;
    end else begin
      busy_q <= busy_d;
      sub_q  <= sub_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (job_q.deliver || job_q.deselect || job_q.issue || job_q.strobe || job_q.done))
    else $error("back holds a job with no result left");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !last) |=> busy_q)
    else $error("job dropped before its last result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !pop_i) |=> (busy_q && $stable(sub_q)))
    else $error("unaccepted result changed");

endmodule

// ===== hw/rtl/nand_page_read_bad_block_skip_core.sv =====
// NAND large-page read sequencer with bad-block skipping: a start item gives a
// byte address and a length, and the block answers with the bus actions of each
// page read (select, 00h, two column and three row bytes, 30h), a strobe per
// ready event and per data byte that ends neither page nor read, and each delivered
// byte with its buffer index. At a block boundary the spare byte at the end of the
// page is read first and a block whose mark is not FFh is skipped. One input item
// is taken per cycle while the job queue has room; result items leave at one per
// cycle while pop is asserted, and an item causes up to 10 results, so the result
// side is what sets the sustained rate. Depends on nprbs_pkg.
module nand_page_read_bad_block_skip_core
  import nprbs_pkg::*;
#(
  parameter int unsigned PAGE_BYTES  = 2048,
  parameter int unsigned BLOCK_BYTES = 131072,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  logic accept;
  logic job_valid, q_empty, q_pop;
  job_t front_job, head_job;

  assign accept = push && !full;

  nprbs_front #(
    .PAGE_BYTES (PAGE_BYTES),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .job_valid_o(job_valid),
    .job_o      (front_job)
  );

  nprbs_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_valid),
    .job_i  (front_job),
    .full_o (full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .job_o  (head_job)
  );

  nprbs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_empty_i(q_empty),
    .job_i      (head_job),
    .job_pop_o  (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_item_o)
  );

endmodule
